// ===== hdl/spqm_pkg.sv =====
// spqm_pkg: constants, types and arithmetic helpers for the seat pressure quadrant monitor
// no dependencies; imported by seat_pressure_quadrant_monitor
package spqm_pkg;

	localparam int SENSORS     = 9;
	localparam int CAL_FRAMES  = 10;
	localparam int SAMPLE_BITS = 10;
	localparam int QUADS       = 4;
	localparam int QUAD_SIZE   = 4;
	localparam int LEVEL_BITS  = 3;

	// per-sensor sums hold up to sixteen frames of samples
	localparam int SUM_BITS   = SAMPLE_BITS + 4;
	localparam int QSUM_BITS  = SAMPLE_BITS + 2;
	localparam int MULT_BITS  = SAMPLE_BITS + 3;
	localparam int PRES_BITS  = SAMPLE_BITS + 6;
	localparam int CNT_BITS   = 4;

	// reciprocal divide: floor(x / d) = (x * ceil(2^k / d)) >> k, exact for x < 2^(k-4)
	localparam int DIV_SHIFT  = SUM_BITS + 4;
	localparam int PROD_BITS  = SUM_BITS + DIV_SHIFT + 1;
	localparam longint RECIP_CAL  = ((64'd1 << DIV_SHIFT) + CAL_FRAMES - 1) / CAL_FRAMES;
	localparam longint RECIP_SENS = ((64'd1 << DIV_SHIFT) + SENSORS - 1) / SENSORS;

	localparam int S_TDATA_BITS = ((SENSORS * SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_FIELD_BITS = QUADS * LEVEL_BITS + 2;
	localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

	// quadrant membership: front left, front right, rear left, rear right
	localparam int QUAD_MEMBERS [QUADS][QUAD_SIZE] = '{
		'{4, 1, 0, 3},
		'{7, 4, 3, 6},
		'{5, 2, 1, 4},
		'{8, 5, 4, 7}
	};

	typedef enum logic [LEVEL_BITS-1:0] {
		LVL_NONE,
		LVL_REALLY_LOW,
		LVL_LOW,
		LVL_NORMAL,
		LVL_HIGH,
		LVL_REALLY_HIGH
	} level_t;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_BITS-1:0]    sum_t;

	function automatic sum_t div_cal(input sum_t x);
		logic [PROD_BITS-1:0] prod;
		prod = PROD_BITS'(x) * PROD_BITS'(RECIP_CAL);
		return SUM_BITS'(prod >> DIV_SHIFT);
	endfunction

	function automatic sum_t div_sens(input sum_t x);
		logic [PROD_BITS-1:0] prod;
		prod = PROD_BITS'(x) * PROD_BITS'(RECIP_SENS);
		return SUM_BITS'(prod >> DIV_SHIFT);
	endfunction

	// boundaries at a quarter, half, one and a half and seven quarters of the reference
	function automatic level_t level_of(input sample_t cur, input sample_t ref_val);
		logic [MULT_BITS-1:0] c;
		logic [MULT_BITS-1:0] r1;
		logic [MULT_BITS-1:0] r2;
		logic [MULT_BITS-1:0] r6;
		logic [MULT_BITS-1:0] r7;
		level_t lvl;
		c  = MULT_BITS'({cur, 2'b00});
		r1 = MULT_BITS'(ref_val);
		r2 = r1 << 1;
		r6 = (r1 << 2) + (r1 << 1);
		r7 = (r1 << 3) - r1;
		priority if (cur == '0) lvl = LVL_NONE;
		else if (c <= r1)       lvl = LVL_REALLY_LOW;
		else if (c <= r2)       lvl = LVL_LOW;
		else if (c <= r6)       lvl = LVL_NORMAL;
		else if (c <= r7)       lvl = LVL_HIGH;
		else                    lvl = LVL_REALLY_HIGH;
		return lvl;
	endfunction

endpackage

// ===== hdl/seat_pressure_quadrant_monitor.sv =====
// seat_pressure_quadrant_monitor: input register, two work stages and an output register
// one beat per cycle sustained while m_tready stays high
// each stage moves on when the stage after it is empty or moving, so bubbles close up under stall
// calibration sums, frame count and offsets update as a calibration frame leaves the input register
// arst_n clears all valid bits, sums, the frame count and the offsets at once
// depends on spqm_pkg
module seat_pressure_quadrant_monitor
	import spqm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,   // sample_0 .. sample_8, zero padded
	input  logic                    s_tuser,   // action
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata    // level_front_left, level_front_right,
	                                           // level_rear_left, level_rear_right,
	                                           // user_present, calibration_committed, padding
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic step12, step23, step34;

	sample_t smp_s1 [SENSORS];
	logic    action_s1;

	logic [QSUM_BITS-1:0] csum_s2 [QUADS];
	sum_t                 total_s2;
	logic                 committed_s2;

	sample_t cur_s3 [QUADS];
	sample_t ref_s3 [QUADS];
	sample_t base_s3;
	sum_t    total_s3;
	logic    committed_s3;

	level_t  level_s4 [QUADS];
	logic    present_s4;
	logic    committed_s4;

	sum_t                cal_sums_q [SENSORS];
	logic [CNT_BITS-1:0] cal_count_q;
	sample_t             offsets_q [SENSORS];

	sum_t                 new_sum [SENSORS];
	logic                 commit_s1;
	logic [QSUM_BITS-1:0] csum_c [QUADS];
	sum_t                 total_c;
	logic [QSUM_BITS-1:0] rsum_c [QUADS];
	sum_t                 osum_c;
	logic [PRES_BITS-1:0] pres_lhs, pres_rhs;
	logic                 sums_clear;

	assign en4 = !v_s4 || m_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign step12 = v_s1 && en2;
	assign step23 = v_s2 && en3;
	assign step34 = v_s3 && en4;

	assign s_tready = en1;
	assign m_tvalid = v_s4;

	// stage 1 work: accumulate, form the quadrant sums and total, and detect the last calibration frame
	always_comb begin
		total_c = '0;
		for (int i = 0; i < SENSORS; i++) begin
			new_sum[i] = cal_sums_q[i] + SUM_BITS'(smp_s1[i]);
			total_c = total_c + SUM_BITS'(smp_s1[i]);
		end
		for (int q = 0; q < QUADS; q++) begin
			csum_c[q] = '0;
			for (int k = 0; k < QUAD_SIZE; k++) begin
				csum_c[q] = csum_c[q] + QSUM_BITS'(smp_s1[QUAD_MEMBERS[q][k]]);
			end
		end
		commit_s1 = !action_s1 && (cal_count_q == CNT_BITS'(CAL_FRAMES - 1));
	end

	// stage 2 work: quadrant references and base from the offsets as they now stand
	always_comb begin
		osum_c = '0;
		for (int i = 0; i < SENSORS; i++) begin
			osum_c = osum_c + SUM_BITS'(offsets_q[i]);
		end
		for (int q = 0; q < QUADS; q++) begin
			rsum_c[q] = '0;
			for (int k = 0; k < QUAD_SIZE; k++) begin
				rsum_c[q] = rsum_c[q] + QSUM_BITS'(offsets_q[QUAD_MEMBERS[q][k]]);
			end
		end
	end

	// stage 3 work: 4*total against 27*base
	always_comb begin
		pres_lhs = PRES_BITS'({total_s3, 2'b00});
		pres_rhs = (PRES_BITS'(base_s3) << 4) + (PRES_BITS'(base_s3) << 3)
			+ (PRES_BITS'(base_s3) << 1) + PRES_BITS'(base_s3);
	end

	always_comb begin
		m_tdata = '0;
		for (int q = 0; q < QUADS; q++) begin
			m_tdata[q*LEVEL_BITS +: LEVEL_BITS] = level_s4[q];
		end
		m_tdata[QUADS*LEVEL_BITS]     = present_s4;
		m_tdata[QUADS*LEVEL_BITS + 1] = committed_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			cal_count_q <= '0;
			for (int i = 0; i < SENSORS; i++) begin
				cal_sums_q[i] <= '0;
				offsets_q[i]  <= '0;
			end
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (step12 && !action_s1) begin
				if (commit_s1) begin
					cal_count_q <= '0;
					for (int i = 0; i < SENSORS; i++) begin
						cal_sums_q[i] <= '0;
						offsets_q[i]  <= SAMPLE_BITS'(div_cal(new_sum[i]));
					end
				end else begin
					cal_count_q <= cal_count_q + 1'b1;
					for (int i = 0; i < SENSORS; i++) begin
						cal_sums_q[i] <= new_sum[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && en1) begin
			action_s1 <= s_tuser;
			for (int i = 0; i < SENSORS; i++) begin
				smp_s1[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
			end
		end
		if (step12) begin
			csum_s2      <= csum_c;
			total_s2     <= total_c;
			committed_s2 <= commit_s1;
		end
		if (step23) begin
			for (int q = 0; q < QUADS; q++) begin
				cur_s3[q] <= SAMPLE_BITS'(csum_s2[q] >> 2);
				ref_s3[q] <= SAMPLE_BITS'(rsum_c[q] >> 2);
			end
			base_s3      <= SAMPLE_BITS'(div_sens(osum_c));
			total_s3     <= total_s2;
			committed_s3 <= committed_s2;
		end
		if (step34) begin
			for (int q = 0; q < QUADS; q++) begin
				level_s4[q] <= level_of(cur_s3[q], ref_s3[q]);
			end
			present_s4   <= pres_lhs > pres_rhs;
			committed_s4 <= committed_s3;
		end
	end

	always_comb begin
		sums_clear = 1'b1;
		for (int i = 0; i < SENSORS; i++) begin
			if (cal_sums_q[i] != '0) sums_clear = 1'b0;
		end
	end

	// the frame count never reaches the commit figure
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_count_q < CNT_BITS'(CAL_FRAMES))
		else $error("calibration frame count out of range");

	// a committing beat leaves sums and count cleared
	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step12 && commit_s1) |=> (sums_clear && cal_count_q == '0))
		else $error("calibration state not cleared after commit");

	// measurement beats leave the calibration count alone
	a_measure_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(step12 && action_s1) |=> $stable(cal_count_q))
		else $error("measurement beat changed calibration count");

endmodule
